// File: rtl/lap_pkg.sv
// types and constants for the 3x3 laplacian edge filter
package lap_pkg;

   localparam int PIXEL_W   = 8;
   localparam int DIM_W     = 12;
   localparam int OUT_ROW_W = 12;
   localparam int OUT_COL_W = 11;
   localparam int CSR_IDX_W = 1;
   localparam int SUM_W     = 12;
   localparam int MIN_DIM   = 3;
   localparam int RESET_WIDTH  = 640;
   localparam int RESET_HEIGHT = 480;
   localparam int CENTER_SHIFT = 3;

   typedef logic [PIXEL_W-1:0]   pixel_type;
   typedef logic [DIM_W-1:0]     dim_type;
   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_IMAGE_WIDTH  = csr_index_type'(0);
   localparam csr_index_type CSR_IMAGE_HEIGHT = csr_index_type'(1);

   localparam pixel_type PIXEL_MAX = pixel_type'(255);

endpackage

// File: rtl/laplacian_3x3_edge_filter.sv
// 3x3 laplacian edge filter (8-neighbour kernel) on a raster pixel stream
// path: each accepted request goes through the request register, then the output register
// one request per cycle unless stalled; two line memories read and written once per pixel
// reset: counters, window and valids clear; width 640, height 480; line memories not cleared
// border pixels give no result
module laplacian_3x3_edge_filter
   import lap_pkg::*;
#(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_pixel,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_value,
   output logic [11:0]          rsp_out_row,
   output logic [10:0]          rsp_out_col,
   output logic                 rsp_frame_end,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_data
);

   localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int EW = CW + 1;
   localparam int RESET_W = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

   // frame geometry, stored clamped
   logic [EW-1:0] eff_w_ff, eff_w_in;
   dim_type       eff_h_ff, eff_h_in;

   // position counters
   logic [CW-1:0] col_ff, col_in;
   dim_type       row_ff, row_in;

   // request register with registered memory reads
   logic          s1_valid_ff, s1_valid_in;
   pixel_type     s1_pixel_ff;
   logic [CW-1:0] s1_col_ff;
   dim_type       s1_row_ff;
   pixel_type     top_ff;
   pixel_type     mid_ff;

   pixel_type     upper_mem [MAX_WIDTH];
   pixel_type     middle_mem [MAX_WIDTH];

   pixel_type     win_ff [6];

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   pixel_type     rsp_value_ff, rsp_value_in;
   logic [OUT_ROW_W-1:0] rsp_row_ff, rsp_row_in;
   logic [OUT_COL_W-1:0] rsp_col_ff, rsp_col_in;
   logic          rsp_end_ff, rsp_end_in;

   logic          out_free;
   logic          advance;
   logic          accept;
   logic          produce;
   logic          last_col;
   logic [SUM_W-1:0] nb_sum;
   logic [SUM_W-1:0] center_x8;
   logic [SUM_W-1:0] diff;
   logic [SUM_W-1:0] mag;
   logic [CW-1:0]    col_m1;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   // configuration and counters
   always_comb begin
      int v;
      v = int'(csr_data);
      eff_w_in = eff_w_ff;
      eff_h_in = eff_h_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      last_col = ({1'b0, col_ff} == eff_w_ff - EW'(1));
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = (row_ff == eff_h_ff - DIM_W'(1)) ? '0 : row_ff + DIM_W'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
      if (csr_write) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH: begin
               if (v < MIN_DIM) v = MIN_DIM;
               if (v > MAX_WIDTH) v = MAX_WIDTH;
               eff_w_in = EW'(v);
            end
            CSR_IMAGE_HEIGHT: begin
               if (v < MIN_DIM) v = MIN_DIM;
               eff_h_in = DIM_W'(v);
            end
            default: begin
            end
         endcase
         col_in = '0;
         row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_w_ff <= EW'(RESET_W);
         eff_h_ff <= DIM_W'(RESET_HEIGHT);
         col_ff   <= '0;
         row_ff   <= '0;
      end else begin
         eff_w_ff <= eff_w_in;
         eff_h_ff <= eff_h_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
      end
   end

   // request register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= req_pixel;
         s1_col_ff   <= col_ff;
         s1_row_ff   <= row_ff;
      end
   end

   // line memories
   always_ff @(posedge clock) begin
      if (accept) begin
         top_ff <= upper_mem[col_ff];
         mid_ff <= middle_mem[col_ff];
      end
      if (advance) begin
         upper_mem[s1_col_ff]  <= mid_ff;
         middle_mem[s1_col_ff] <= s1_pixel_ff;
      end
   end

   // window: 0..2 column c-2 (top, mid, bottom), 3..5 column c-1
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (advance) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= top_ff;
         win_ff[4] <= mid_ff;
         win_ff[5] <= s1_pixel_ff;
      end
   end

   // kernel
   always_comb begin
      produce   = (s1_row_ff > DIM_W'(1)) && (s1_col_ff > CW'(1));
      nb_sum    = SUM_W'(win_ff[0]) + SUM_W'(win_ff[1]) + SUM_W'(win_ff[2])
                + SUM_W'(win_ff[3]) + SUM_W'(win_ff[5]) + SUM_W'(top_ff)
                + SUM_W'(mid_ff) + SUM_W'(s1_pixel_ff);
      center_x8 = SUM_W'(win_ff[4]) << CENTER_SHIFT;
      diff      = nb_sum - center_x8;
      mag       = diff[SUM_W-1] ? (center_x8 - nb_sum) : diff;
      col_m1    = s1_col_ff - CW'(1);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_end_in   = rsp_end_ff;
      if (advance) begin
         rsp_valid_in = produce;
         rsp_value_in = (mag > SUM_W'(PIXEL_MAX)) ? PIXEL_MAX : mag[PIXEL_W-1:0];
         rsp_row_in   = OUT_ROW_W'(s1_row_ff - DIM_W'(1));
         rsp_col_in   = OUT_COL_W'(col_m1);
         rsp_end_in   = (s1_row_ff == eff_h_ff - DIM_W'(1))
                     && ({1'b0, s1_col_ff} == eff_w_ff - EW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_end_ff   <= rsp_end_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value     = rsp_value_ff;
   assign rsp_out_row   = rsp_row_ff;
   assign rsp_out_col   = rsp_col_ff;
   assign rsp_frame_end = rsp_end_ff;

endmodule

// File: tb/laplacian_3x3_edge_filter_test.sv
// self-checking testbench for the 3x3 laplacian edge filter: pixel stream, scoreboard, stalls
module laplacian_3x3_edge_filter_test
   import lap_pkg::*;
();

   localparam int LINE_DEPTH      = 2048;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 4;
   localparam int DIRECTED_COUNT  = 27;

   typedef logic [OUT_ROW_W-1:0] row_type;
   typedef logic [OUT_COL_W-1:0] col_type;

   typedef struct {
      pixel_type value;
      row_type   row;
      col_type   col;
      logic      frame_end;
   } edge_result_type;

   class laplacian_scoreboard;
      dim_type         width_reg;
      dim_type         height_reg;
      pixel_type       upper_line [LINE_DEPTH];
      pixel_type       middle_line [LINE_DEPTH];
      pixel_type       window [6];
      int unsigned     col;
      int unsigned     row;
      edge_result_type expected_edges [$];
      int              mismatches;

      function new();
         width_reg = dim_type'(RESET_WIDTH);
         height_reg = dim_type'(RESET_HEIGHT);
         foreach (upper_line[i]) begin
            upper_line[i] = '0;
            middle_line[i] = '0;
         end
         foreach (window[i]) window[i] = '0;
         col = 0;
         row = 0;
         mismatches = 0;
      endfunction

      function int pending();
         return expected_edges.size();
      endfunction

      function void set_register(csr_index_type idx, dim_type data);
         case (idx)
            CSR_IMAGE_WIDTH: width_reg = data;
            CSR_IMAGE_HEIGHT: height_reg = data;
            default: ;
         endcase
         col = 0;
         row = 0;
      endfunction

      function void note_pixel(pixel_type p);
         int unsigned     w;
         int unsigned     h;
         int              sum;
         pixel_type       top;
         pixel_type       mid;
         edge_result_type res;
         w = width_reg;
         if (w < MIN_DIM) w = MIN_DIM;
         if (w > LINE_DEPTH) w = LINE_DEPTH;
         h = height_reg;
         if (h < MIN_DIM) h = MIN_DIM;
         top = upper_line[col];
         mid = middle_line[col];
         if (row >= 2 && col >= 2) begin
            sum = int'(window[0]) + int'(window[1]) + int'(window[2]) + int'(window[3])
                + int'(window[5]) + int'(top) + int'(mid) + int'(p) - 8 * int'(window[4]);
            if (sum < 0) sum = -sum;
            if (sum > int'(PIXEL_MAX)) sum = int'(PIXEL_MAX);
            res.value = pixel_type'(sum);
            res.row = row_type'(row - 1);
            res.col = col_type'(col - 1);
            res.frame_end = (row == h - 1) && (col == w - 1);
            expected_edges.push_back(res);
         end
         window[0] = window[3];
         window[1] = window[4];
         window[2] = window[5];
         window[3] = top;
         window[4] = mid;
         window[5] = p;
         upper_line[col] = mid;
         middle_line[col] = p;
         if (col + 1 >= w) begin
            col = 0;
            row = (row + 1 >= h) ? 0 : row + 1;
         end else begin
            col = col + 1;
         end
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         mismatches++;
      endtask

      task check_result(pixel_type value, row_type r, col_type c, logic frame_end);
         edge_result_type exp;
         if (expected_edges.size() == 0) begin
            report($sformatf("result at row %0d col %0d with no request pending", r, c));
         end else begin
            exp = expected_edges.pop_front();
            if (value !== exp.value)
               report($sformatf("row %0d col %0d value %0d, expected %0d",
                                exp.row, exp.col, value, exp.value));
            if (r !== exp.row)
               report($sformatf("out_row %0d, expected %0d", r, exp.row));
            if (c !== exp.col)
               report($sformatf("out_col %0d, expected %0d", c, exp.col));
            if (frame_end !== exp.frame_end)
               report($sformatf("row %0d col %0d frame_end %0b, expected %0b",
                                exp.row, exp.col, frame_end, exp.frame_end));
         end
      endtask
   endclass

   logic          clock;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   pixel_type     req_pixel = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   pixel_type     rsp_value;
   row_type       rsp_out_row;
   col_type       rsp_out_col;
   logic          rsp_frame_end;
   logic          csr_write = 1'b0;
   csr_index_type csr_index = CSR_IMAGE_WIDTH;
   dim_type       csr_data = '0;

   laplacian_scoreboard filter_model;
   int req_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_request = 0;
   int hold_left = 0;

   pixel_type directed_pixels [DIRECTED_COUNT] = '{
      8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   8'd255, 8'd255, 8'd255, 8'd255,
      8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd0,   8'd0,
      8'd1,   8'd0,   8'd0,   8'd0,   8'd32,  8'd0,   8'd0,   8'd0,   8'd0
   };

   laplacian_3x3_edge_filter #(
      .MAX_WIDTH(LINE_DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_pixel(req_pixel),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_value(rsp_value),
      .rsp_out_row(rsp_out_row),
      .rsp_out_col(rsp_out_col),
      .rsp_frame_end(rsp_frame_end),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("** laplacian_3x3_edge_filter: FAILED **");
      $finish;
   end

   // result side: check, then pick the stall for the next cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         filter_model.check_result(rsp_value, rsp_out_row, rsp_out_col, rsp_frame_end);
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   function automatic pixel_type random_pixel();
      case ($urandom_range(7))
         0: return '0;
         1: return PIXEL_MAX;
         default: return pixel_type'($urandom_range(255));
      endcase
   endfunction

   task automatic send_pixel(pixel_type p);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      filter_model.note_pixel(p);
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (filter_model.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(dim_type w, dim_type h);
      wait_drained();
      csr_write <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_data <= w;
      @(posedge clock);
      filter_model.set_register(CSR_IMAGE_WIDTH, w);
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_data <= h;
      @(posedge clock);
      filter_model.set_register(CSR_IMAGE_HEIGHT, h);
      csr_write <= 1'b0;
   endtask

   task automatic random_burst(int count, int idle_pct, int stall_pct, bit hold, bit pause);
      req_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) begin
         if (hold && i == count / 4) hold_request = HOLD_OFF_CYCLES;
         // with pause set, wait at the midpoint until every expected result has come back
         if (pause && i == count / 2) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (filter_model.pending() != 0) @(posedge clock);
         end
         send_pixel(random_pixel());
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      filter_model = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset geometry: first row only, no results
      random_burst(40, 0, 0, 1'b0, 1'b0);

      // widths and heights below the minimum clamp to 3
      configure(dim_type'(0), dim_type'(2));
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      foreach (directed_pixels[i]) send_pixel(directed_pixels[i]);
      req_valid <= 1'b0;

      configure(dim_type'(7), dim_type'(5));
      random_burst(100, 0, 0, 1'b0, 1'b1);
      configure(dim_type'(3), dim_type'(3));
      random_burst(100, 86, 0, 1'b0, 1'b0);
      configure(dim_type'(10), dim_type'(4));
      random_burst(120, 0, 86, 1'b0, 1'b0);
      configure(dim_type'(4), dim_type'(6));
      random_burst(100, 24, 24, 1'b0, 1'b0);
      configure(dim_type'(13), dim_type'(3));
      random_burst(100, 0, 0, 1'b1, 1'b0);

      // widest line, clamped from the register maximum, then the tallest frame
      configure(dim_type'(4095), dim_type'(3));
      random_burst(20, 0, 0, 1'b0, 1'b0);
      configure(dim_type'(3), dim_type'(4095));
      random_burst(45, 0, 0, 1'b0, 1'b0);

      configure(dim_type'(5), dim_type'(3));
      random_burst(60, 24, 24, 1'b0, 1'b0);

      wait_drained();
      if (filter_model.mismatches == 0)
         $display("** laplacian_3x3_edge_filter: PASSED **");
      else
         $display("** laplacian_3x3_edge_filter: FAILED **");
      $finish;
   end

endmodule

// File: laplacian_3x3_edge_filter.f
rtl/lap_pkg.sv
rtl/laplacian_3x3_edge_filter.sv
tb/laplacian_3x3_edge_filter_test.sv
